>>> src/qtd_pkg.sv
package qtd_pkg;

	localparam int COEFF_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int NUM_SLOTS       = 20;

	typedef logic [4:0] slot_t;
	typedef logic [6:0] addr_t;

	localparam slot_t LAST_SLOT = 5'(NUM_SLOTS - 1);

	localparam logic [1:0] BANK_N = 2'd0;
	localparam logic [1:0] BANK_D = 2'd1;
	localparam logic [1:0] BANK_Q = 2'd2;
	localparam logic [1:0] BANK_T = 2'd3;

	localparam addr_t ADDR_ZERO = {BANK_T, 5'd31};

	typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;
	typedef enum logic [1:0] {PH_Q0, PH_FIRST, PH_SECOND, PH_THIRD} phase_t;
	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD_D, ST_FETCH, ST_EXEC, ST_WAIT, ST_OUT_RD, ST_OUT_EMIT
	} state_t;
	typedef enum logic [1:0] {WSRC_NUM, WSRC_DEN, WSRC_RES} wsrc_t;

	typedef struct packed {
		op_t   op;
		addr_t a;
		addr_t b;
		addr_t dst;
		logic  last;
	} instr_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		wsrc_t wsrc;
		addr_t raddr_a;
		addr_t raddr_b;
		logic  load_in;
		logic  start;
		op_t   op;
		logic  out_load;
		slot_t out_slot;
		logic  out_end;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic d0_zero;
		logic out_free;
	} sts_t;

	localparam slot_t SEC_TAB [6][3] = '{
		'{5'd4, 5'd1, 5'd1}, '{5'd5, 5'd2, 5'd2}, '{5'd6, 5'd3, 5'd3},
		'{5'd7, 5'd1, 5'd2}, '{5'd8, 5'd2, 5'd3}, '{5'd9, 5'd1, 5'd3}
	};

	localparam slot_t THIRD_TAB [10][17] = '{
		'{5'd10, 5'd1,5'd4, 5'd4,5'd1, 5'd1,5'd4, 5'd1,5'd4, 5'd1, 5'd1,5'd1, 5'd4, 5'd1, 5'd4, 5'd1,5'd1},
		'{5'd11, 5'd2,5'd5, 5'd5,5'd2, 5'd2,5'd5, 5'd2,5'd5, 5'd2, 5'd2,5'd2, 5'd5, 5'd2, 5'd5, 5'd2,5'd2},
		'{5'd12, 5'd3,5'd6, 5'd6,5'd3, 5'd3,5'd6, 5'd3,5'd6, 5'd3, 5'd3,5'd3, 5'd6, 5'd3, 5'd6, 5'd3,5'd3},
		'{5'd13, 5'd3,5'd4, 5'd9,5'd1, 5'd1,5'd9, 5'd3,5'd4, 5'd1, 5'd3,5'd1, 5'd9, 5'd1, 5'd9, 5'd1,5'd3},
		'{5'd14, 5'd2,5'd4, 5'd7,5'd1, 5'd1,5'd7, 5'd2,5'd4, 5'd1, 5'd2,5'd1, 5'd7, 5'd1, 5'd7, 5'd1,5'd2},
		'{5'd15, 5'd3,5'd5, 5'd8,5'd2, 5'd2,5'd8, 5'd3,5'd5, 5'd2, 5'd3,5'd2, 5'd8, 5'd2, 5'd8, 5'd2,5'd3},
		'{5'd16, 5'd1,5'd5, 5'd7,5'd2, 5'd2,5'd7, 5'd1,5'd5, 5'd2, 5'd1,5'd2, 5'd7, 5'd2, 5'd7, 5'd2,5'd1},
		'{5'd17, 5'd1,5'd6, 5'd9,5'd3, 5'd3,5'd9, 5'd1,5'd6, 5'd3, 5'd1,5'd3, 5'd9, 5'd3, 5'd9, 5'd3,5'd1},
		'{5'd18, 5'd2,5'd6, 5'd8,5'd3, 5'd3,5'd8, 5'd2,5'd6, 5'd3, 5'd2,5'd3, 5'd8, 5'd3, 5'd8, 5'd3,5'd2},
		'{5'd19, 5'd3,5'd7, 5'd8,5'd1, 5'd2,5'd9, 5'd3,5'd7, 5'd1, 5'd3,5'd2, 5'd8, 5'd2, 5'd9, 5'd1,5'd3}
	};

	function automatic addr_t an(input slot_t i);
		return {BANK_N, i};
	endfunction

	function automatic addr_t ad(input slot_t i);
		return {BANK_D, i};
	endfunction

	function automatic addr_t aq(input slot_t i);
		return {BANK_Q, i};
	endfunction

	function automatic addr_t at(input logic [1:0] j);
		return {BANK_T, 3'd0, j};
	endfunction

	function automatic instr_t mk(input op_t op, input addr_t a, input addr_t b,
		input addr_t dst, input logic last);
		instr_t ins;
		ins.op   = op;
		ins.a    = a;
		ins.b    = b;
		ins.dst  = dst;
		ins.last = last;
		return ins;
	endfunction

	function automatic instr_t prog_instr(input phase_t ph, input logic [3:0] g,
		input logic [4:0] s);
		instr_t ins;
		slot_t  i;
		slot_t  k;
		slot_t  a;
		slot_t  b;
		slot_t  r [17];
		i   = 5'(g) + 5'd1;
		k   = SEC_TAB[g[2:0]][0];
		a   = SEC_TAB[g[2:0]][1];
		b   = SEC_TAB[g[2:0]][2];
		r   = THIRD_TAB[g];
		ins = mk(OP_ADD, ADDR_ZERO, ADDR_ZERO, at(2'd0), 1'b1);
		case (ph)
			PH_Q0: ins = mk(OP_DIV, an(5'd0), ad(5'd0), aq(5'd0), 1'b1);
			PH_FIRST: begin
				case (s)
					5'd0: ins = mk(OP_MUL, an(5'd0), ad(i), at(2'd0), 1'b0);
					5'd1: ins = mk(OP_DIV, at(2'd0), ad(5'd0), at(2'd0), 1'b0);
					5'd2: ins = mk(OP_SUB, an(i), at(2'd0), at(2'd0), 1'b0);
					5'd3: ins = mk(OP_DIV, at(2'd0), ad(5'd0), aq(i), 1'b1);
					default: ins = mk(OP_ADD, ADDR_ZERO, ADDR_ZERO, at(2'd0), 1'b1);
				endcase
			end
			PH_SECOND: begin
				case (s)
					5'd0: ins = mk(OP_MUL, ad(b), aq(a), at(2'd0), 1'b0);
					5'd1: ins = mk(OP_SUB, an(k), at(2'd0), at(2'd0), 1'b0);
					5'd2: ins = mk(OP_MUL, aq(5'd0), ad(k), at(2'd1), 1'b0);
					5'd3: ins = mk(OP_SUB, at(2'd0), at(2'd1), at(2'd0), 1'b0);
					5'd4: ins = mk(OP_MUL, aq(5'd0), ad(b), at(2'd1), 1'b0);
					5'd5: ins = mk(OP_SUB, at(2'd1), an(b), at(2'd1), 1'b0);
					5'd6: ins = mk(OP_MUL, ad(a), at(2'd1), at(2'd1), 1'b0);
					5'd7: ins = mk(OP_DIV, at(2'd1), ad(5'd0), at(2'd1), 1'b0);
					5'd8: ins = mk(OP_ADD, at(2'd0), at(2'd1), at(2'd0), 1'b0);
					5'd9: ins = mk(OP_DIV, at(2'd0), ad(5'd0), aq(k), 1'b1);
					default: ins = mk(OP_ADD, ADDR_ZERO, ADDR_ZERO, at(2'd0), 1'b1);
				endcase
			end
			PH_THIRD: begin
				case (s)
					5'd0:  ins = mk(OP_SUB, ADDR_ZERO, ad(r[1]), at(2'd0), 1'b0);
					5'd1:  ins = mk(OP_MUL, at(2'd0), aq(r[2]), at(2'd0), 1'b0);
					5'd2:  ins = mk(OP_ADD, at(2'd0), an(r[0]), at(2'd0), 1'b0);
					5'd3:  ins = mk(OP_MUL, ad(r[3]), aq(r[4]), at(2'd1), 1'b0);
					5'd4:  ins = mk(OP_SUB, at(2'd0), at(2'd1), at(2'd0), 1'b0);
					5'd5:  ins = mk(OP_MUL, ad(r[5]), aq(r[6]), at(2'd1), 1'b0);
					5'd6:  ins = mk(OP_SUB, at(2'd0), at(2'd1), at(2'd0), 1'b0);
					5'd7:  ins = mk(OP_MUL, aq(r[7]), ad(r[8]), at(2'd1), 1'b0);
					5'd8:  ins = mk(OP_SUB, at(2'd0), at(2'd1), at(2'd0), 1'b0);
					5'd9:  ins = mk(OP_MUL, aq(5'd0), ad(r[0]), at(2'd1), 1'b0);
					5'd10: ins = mk(OP_SUB, at(2'd0), at(2'd1), at(2'd0), 1'b0);
					5'd11: ins = mk(OP_MUL, aq(r[10]), ad(r[11]), at(2'd1), 1'b0);
					5'd12: ins = mk(OP_MUL, aq(5'd0), ad(r[12]), at(2'd2), 1'b0);
					5'd13: ins = mk(OP_ADD, at(2'd1), at(2'd2), at(2'd1), 1'b0);
					5'd14: ins = mk(OP_SUB, at(2'd1), an(r[12]), at(2'd1), 1'b0);
					5'd15: ins = mk(OP_MUL, ad(r[9]), at(2'd1), at(2'd1), 1'b0);
					5'd16: ins = mk(OP_MUL, aq(5'd0), ad(r[13]), at(2'd2), 1'b0);
					5'd17: ins = mk(OP_SUB, at(2'd2), an(r[13]), at(2'd2), 1'b0);
					5'd18: ins = mk(OP_MUL, ad(r[15]), ad(r[16]), at(2'd3), 1'b0);
					5'd19: ins = mk(OP_DIV, at(2'd3), ad(5'd0), at(2'd3), 1'b0);
					5'd20: ins = mk(OP_SUB, ad(r[14]), at(2'd3), at(2'd3), 1'b0);
					5'd21: ins = mk(OP_MUL, at(2'd2), at(2'd3), at(2'd2), 1'b0);
					5'd22: ins = mk(OP_ADD, at(2'd1), at(2'd2), at(2'd1), 1'b0);
					5'd23: ins = mk(OP_DIV, at(2'd1), ad(5'd0), at(2'd1), 1'b0);
					5'd24: ins = mk(OP_ADD, at(2'd0), at(2'd1), at(2'd0), 1'b0);
					5'd25: ins = mk(OP_DIV, at(2'd0), ad(5'd0), aq(r[0]), 1'b1);
					default: ins = mk(OP_ADD, ADDR_ZERO, ADDR_ZERO, at(2'd0), 1'b1);
				endcase
			end
			default: ins = mk(OP_ADD, ADDR_ZERO, ADDR_ZERO, at(2'd0), 1'b1);
		endcase
		return ins;
	endfunction

endpackage

>>> src/qtd_arith.sv
module qtd_arith
	import qtd_pkg::*;
#(
	parameter int COEFF_WIDTH = COEFF_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  op_t                    op,
	input  logic [COEFF_WIDTH-1:0] a,
	input  logic [COEFF_WIDTH-1:0] b,
	output logic                   done,
	output logic [COEFF_WIDTH-1:0] res
);

	localparam int W  = COEFF_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int DW = W + F;
	localparam int EW = 2 * W + F;
	localparam int CW = $clog2(DW + 1);

	localparam logic [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  VMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [EW-1:0] HALF = EW'(1) << (W - 1);

	logic          busy_q;
	logic          fin_q;
	logic          done_q;
	op_t           op_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [W-1:0]  ua_q;
	logic [W-1:0]  ub_q;
	logic [2*W-1:0] mp_q;
	logic [W-1:0]  rem_q;
	logic [DW-1:0] dq_q;
	logic [W-1:0]  res_q;

	logic [W-1:0]   ua;
	logic [W-1:0]   ub;
	logic [W:0]     sum;
	logic [W-1:0]   addsub;
	logic [W:0]     msum;
	logic [W:0]     r2;
	logic           ge;
	logic [W:0]     rdiff;
	logic [CW-1:0]  cnt_last;
	logic [2*W-1:0] pshift;
	logic           dropped;
	logic [2*W-1:0] pr;
	logic [EW-1:0]  mag_ext;
	logic [EW-1:0]  neg_ext;
	logic [W-1:0]   fin_res;

	assign ua = a[W-1] ? (~a + W'(1)) : a;
	assign ub = b[W-1] ? (~b + W'(1)) : b;

	always_comb begin
		if (op == OP_SUB) begin
			sum = {a[W-1], a} - {b[W-1], b};
		end else begin
			sum = {a[W-1], a} + {b[W-1], b};
		end
		if (sum[W] != sum[W-1]) begin
			addsub = sum[W] ? VMIN : VMAX;
		end else begin
			addsub = sum[W-1:0];
		end
	end

	assign msum     = {1'b0, mp_q[2*W-1:W]} + (mp_q[0] ? {1'b0, ua_q} : '0);
	assign r2       = {rem_q, dq_q[DW-1]};
	assign ge       = r2 >= {1'b0, ub_q};
	assign rdiff    = r2 - {1'b0, ub_q};
	assign cnt_last = (op_q == OP_MUL) ? CW'(W - 1) : CW'(DW - 1);

	always_comb begin
		pshift  = mp_q >> F;
		dropped = (pshift << F) != mp_q;
		pr      = pshift + {{(2*W-1){1'b0}}, neg_q & dropped};
		if (op_q == OP_MUL) begin
			mag_ext = EW'(pr);
		end else begin
			mag_ext = EW'(dq_q);
		end
		neg_ext = ~mag_ext + EW'(1);
		if (op_q == OP_DIV && ub_q == '0) begin
			fin_res = '0;
		end else if (neg_q) begin
			fin_res = (mag_ext >= HALF) ? VMIN : neg_ext[W-1:0];
		end else begin
			fin_res = (mag_ext > HALF - EW'(1)) ? VMAX : mag_ext[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				if (op == OP_ADD || op == OP_SUB) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == cnt_last) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= op;
			neg_q <= a[W-1] ^ b[W-1];
			ua_q  <= ua;
			ub_q  <= ub;
			mp_q  <= {{W{1'b0}}, ub};
			rem_q <= '0;
			dq_q  <= {ua, {F{1'b0}}};
			if (op == OP_ADD || op == OP_SUB) begin
				res_q <= addsub;
			end
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				mp_q <= {msum, mp_q[W-1:1]};
			end else begin
				rem_q <= ge ? rdiff[W-1:0] : r2[W-1:0];
				dq_q  <= {dq_q[DW-2:0], ge};
			end
		end else if (fin_q) begin
			res_q <= fin_res;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> src/qtd_datapath.sv
module qtd_datapath
	import qtd_pkg::*;
#(
	parameter int COEFF_WIDTH = COEFF_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	input  logic signed [COEFF_WIDTH-1:0] numerator_coeff,
	input  logic signed [COEFF_WIDTH-1:0] denominator_coeff,
	input  logic                          out_stall,
	output sts_t                          sts,
	output logic                          out_valid,
	output slot_t                         out_slot,
	output logic signed [COEFF_WIDTH-1:0] quotient_coeff,
	output logic                          run_end,
	output logic                          zero_divisor
);

	localparam int W     = COEFF_WIDTH;
	localparam int DEPTH = 128;

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_a_q;
	logic [W-1:0] rd_b_q;
	logic         za_q;
	logic         zb_q;
	logic [W-1:0] den_q;
	logic         d0z_q;

	logic         out_valid_q;
	slot_t        out_slot_q;
	logic [W-1:0] out_coeff_q;
	logic         out_end_q;
	logic         out_zd_q;

	logic [W-1:0] op_a;
	logic [W-1:0] op_b;
	logic [W-1:0] wdata;
	logic         d0_write;
	logic         a_done;
	logic [W-1:0] a_res;

	assign op_a = za_q ? '0 : rd_a_q;
	assign op_b = zb_q ? '0 : rd_b_q;

	always_comb begin
		case (cmd.wsrc)
			WSRC_NUM: wdata = numerator_coeff;
			WSRC_DEN: wdata = den_q;
			WSRC_RES: wdata = a_res;
			default:  wdata = a_res;
		endcase
	end

	assign d0_write = cmd.we && cmd.wsrc == WSRC_DEN && cmd.waddr == ad(5'd0);

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= wdata;
		end
		rd_a_q <= mem[cmd.raddr_a];
		rd_b_q <= mem[cmd.raddr_b];
		za_q   <= cmd.raddr_a == ADDR_ZERO;
		zb_q   <= cmd.raddr_b == ADDR_ZERO;
		if (cmd.load_in) begin
			den_q <= denominator_coeff;
		end
		if (cmd.out_load) begin
			out_slot_q  <= cmd.out_slot;
			out_coeff_q <= d0z_q ? '0 : rd_a_q;
			out_end_q   <= cmd.out_end;
			out_zd_q    <= d0z_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d0z_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (d0_write) begin
				d0z_q <= den_q == '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	qtd_arith #(
		.COEFF_WIDTH(COEFF_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.op    (cmd.op),
		.a     (op_a),
		.b     (op_b),
		.done  (a_done),
		.res   (a_res)
	);

	assign sts.done     = a_done;
	assign sts.d0_zero  = d0_write ? (den_q == '0) : d0z_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign out_slot       = out_slot_q;
	assign quotient_coeff = out_coeff_q;
	assign run_end        = out_end_q;
	assign zero_divisor   = out_zd_q;

endmodule

>>> src/qtd_ctrl.sv
module qtd_ctrl
	import qtd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  slot_t slot,
	input  logic  final_load,
	input  sts_t  sts,
	output cmd_t  cmd
);

	state_t     state_q;
	state_t     state_d;
	phase_t     phase_q;
	logic [3:0] grp_q;
	logic [4:0] step_q;
	slot_t      k_q;
	slot_t      slot_q;
	logic       final_q;

	instr_t     ins;
	logic [3:0] grp_last;
	logic       prog_end;

	assign ins = prog_instr(phase_q, grp_q, step_q);

	always_comb begin
		case (phase_q)
			PH_Q0:     grp_last = 4'd0;
			PH_FIRST:  grp_last = 4'd2;
			PH_SECOND: grp_last = 4'd5;
			PH_THIRD:  grp_last = 4'd9;
			default:   grp_last = 4'd0;
		endcase
	end

	assign prog_end = ins.last && grp_q == grp_last && phase_q == PH_THIRD;

	always_comb begin
		case (state_q)
			ST_IDLE:     state_d = in_valid ? ST_LOAD_D : ST_IDLE;
			ST_LOAD_D: begin
				if (!final_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = sts.d0_zero ? ST_OUT_RD : ST_FETCH;
				end
			end
			ST_FETCH:    state_d = ST_EXEC;
			ST_EXEC:     state_d = ST_WAIT;
			ST_WAIT: begin
				if (!sts.done) begin
					state_d = ST_WAIT;
				end else begin
					state_d = prog_end ? ST_OUT_RD : ST_FETCH;
				end
			end
			ST_OUT_RD:   state_d = ST_OUT_EMIT;
			ST_OUT_EMIT: begin
				if (!sts.out_free) begin
					state_d = ST_OUT_EMIT;
				end else begin
					state_d = (k_q == LAST_SLOT) ? ST_IDLE : ST_OUT_RD;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_valid;
				cmd.we      = in_valid && slot <= LAST_SLOT;
				cmd.waddr   = an(slot);
				cmd.wsrc    = WSRC_NUM;
			end
			ST_LOAD_D: begin
				cmd.we    = slot_q <= LAST_SLOT;
				cmd.waddr = ad(slot_q);
				cmd.wsrc  = WSRC_DEN;
			end
			ST_FETCH: begin
				cmd.raddr_a = ins.a;
				cmd.raddr_b = ins.b;
			end
			ST_EXEC: begin
				cmd.raddr_a = ins.a;
				cmd.raddr_b = ins.b;
				cmd.start   = 1'b1;
				cmd.op      = ins.op;
			end
			ST_WAIT: begin
				cmd.we    = sts.done;
				cmd.waddr = ins.dst;
				cmd.wsrc  = WSRC_RES;
			end
			ST_OUT_RD: begin
				cmd.raddr_a = aq(k_q);
			end
			ST_OUT_EMIT: begin
				cmd.raddr_a  = aq(k_q);
				cmd.out_load = sts.out_free;
				cmd.out_slot = k_q;
				cmd.out_end  = k_q == LAST_SLOT;
			end
			default: cmd = '0;
		endcase
	end

	assign in_stall = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_Q0;
			grp_q   <= '0;
			step_q  <= '0;
			k_q     <= '0;
			slot_q  <= '0;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						slot_q  <= slot;
						final_q <= final_load;
					end
				end
				ST_LOAD_D: begin
					phase_q <= PH_Q0;
					grp_q   <= '0;
					step_q  <= '0;
					k_q     <= '0;
				end
				ST_WAIT: begin
					if (sts.done) begin
						if (!ins.last) begin
							step_q <= step_q + 5'd1;
						end else begin
							step_q <= '0;
							if (grp_q == grp_last) begin
								grp_q <= '0;
								if (phase_q != PH_THIRD) begin
									phase_q <= phase_t'(phase_q + 2'd1);
								end
							end else begin
								grp_q <= grp_q + 4'd1;
							end
						end
					end
				end
				ST_OUT_EMIT: begin
					if (sts.out_free) begin
						k_q <= k_q + 5'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> src/quotient_taylor_derivatives.sv
// Quotient of two third-order Taylor coefficient sets in three variables, signed
// fixed point (Q16.16 by default). Load the numerator/denominator pairs one slot per
// transfer; each load writes the numerator, then the denominator. The transfer marked
// final_load starts the quotient recurrences: 333 operations run in order on one
// shared unit. The 20 quotient coefficients then leave in slot order. A zero
// denominator value in slot 0 skips the recurrences and returns zeros with
// zero_divisor set. No input transfer is taken during a run.
module quotient_taylor_derivatives
	import qtd_pkg::*;
#(
	parameter int COEFF_WIDTH = COEFF_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [4:0]                    slot,
	input  logic signed [COEFF_WIDTH-1:0] numerator_coeff,
	input  logic signed [COEFF_WIDTH-1:0] denominator_coeff,
	input  logic                          final_load,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [4:0]                    out_slot,
	output logic signed [COEFF_WIDTH-1:0] quotient_coeff,
	output logic                          run_end,
	output logic                          zero_divisor
);

	cmd_t cmd;
	sts_t sts;

	qtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.slot      (slot),
		.final_load(final_load),
		.sts       (sts),
		.cmd       (cmd)
	);

	qtd_datapath #(
		.COEFF_WIDTH(COEFF_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.numerator_coeff  (numerator_coeff),
		.denominator_coeff(denominator_coeff),
		.out_stall        (out_stall),
		.sts              (sts),
		.out_valid        (out_valid),
		.out_slot         (out_slot),
		.quotient_coeff   (quotient_coeff),
		.run_end          (run_end),
		.zero_divisor     (zero_divisor)
	);

endmodule
